[rtl/mac_pkg.sv]
// shared types and constants of the motion alarm controller
`timescale 1ns / 1ps

package mac_pkg;

    // alarm states
    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_ALARM    = 2'd2
    } t_mode;

    // result event codes
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DISARMED = 3'd1,
        EV_ARMED    = 3'd2,
        EV_ALARM    = 3'd3,
        EV_MOTION   = 3'd4,
        EV_TOTAL    = 3'd5,
        EV_STATUS   = 3'd6,
        EV_UNKNOWN  = 3'd7
    } t_event;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd2;

    localparam logic [9:0] BLINK_TICKS_RST    = 10'd25;
    localparam logic [9:0] BEEP_TICKS_RST     = 10'd20;
    localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd5;

    // line terminators and command words
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [23:0] WORD_ARM    = "ARM";
    localparam logic [47:0] WORD_DISARM = "DISARM";
    localparam logic [47:0] WORD_STATUS = "STATUS";

    // one input item
    typedef struct packed {
        logic       cmd;
        logic       motion_level;
        logic       button_level;
        logic [7:0] rx_char;
    } t_item;

    // one result item
    typedef struct packed {
        logic [2:0]  event_code;
        logic [15:0] motion_total;
        logic [1:0]  mode_now;
        logic        red_led;
        logic        green_led;
        logic        tone_on;
        logic        last_of_run;
    } t_result;

endpackage

[rtl/mac_item_if.sv]
// input item channel of the motion alarm controller
`timescale 1ns / 1ps

interface mac_item_if;
    logic           valid;
    logic           ready;
    mac_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/mac_result_if.sv]
// result item channel of the motion alarm controller
`timescale 1ns / 1ps

interface mac_result_if;
    logic             valid;
    logic             ready;
    mac_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/motion_alarm_controller_unit.sv]
// motion alarm controller: three-state intrusion alarm with button and command line
//
// Usage:
// - i_item carries one item per handshake: a 10 ms tick (cmd 0) or one received
//   command character (cmd 1), always with the motion and button levels
// - o_result carries zero, one or two result items per input item, the last one
//   flagged by last_of_run; an item with no result gives nothing on o_result
// - i_cfg_we / i_cfg_idx / i_cfg_wdata write blink, beep and debounce tick counts,
//   only while the block is idle; the block itself does not enforce this
// Timing:
// - one input item is accepted per cycle while i_item.ready is high; its state update is one pass of logic
// - results show on o_result in the cycle after the item is accepted, behind any
//   results still waiting in the queue
// - a four-entry result queue drains one result per cycle while o_result.ready is high,
//   so the two results of an item leave it one after the other
// - i_item.ready is high while the queue holds at most two results, so a stalled
//   receiver holds off new items once three or more results wait
// Reset:
// - synchronous, active low; the block comes up disarmed with default tick counts,
//   an empty command line and an empty result queue
`timescale 1ns / 1ps

module motion_alarm_controller_unit #(
    parameter int LINE_MAX   = 19,
    parameter int WORD_CHARS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mac_item_if.sink                       i_item,
    mac_result_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [mac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mac_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int LEN_W  = $clog2(LINE_MAX + 1);
    localparam int IDX_W  = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int FIFO_D = 4;
    localparam int PTR_W  = 2;
    localparam int CNT_W  = 3;

    // core alarm state plus the results of one item
    typedef struct packed {
        mac_pkg::t_mode  mode;
        logic [15:0]     count;
        logic            prev;
        logic            red;
        logic [9:0]      blink;
        logic [9:0]      beep;
        logic            phase;
        logic [1:0]      n;
        mac_pkg::t_event code0;
        logic [15:0]     tot0;
        mac_pkg::t_event code1;
        logic [15:0]     tot1;
    } t_core;

    // append one result, at most two per item
    function automatic t_core f_emit(t_core s_in, mac_pkg::t_event code, logic [15:0] total);
        t_core s;
        s = s_in;
        priority if (s.n == 2'd0) begin
            s.code0 = code;
            s.tot0  = total;
            s.n     = 2'd1;
        end else if (s.n == 2'd1) begin
            s.code1 = code;
            s.tot1  = total;
            s.n     = 2'd2;
        end
        return s;
    endfunction

    // state change with its side effects and results
    function automatic t_core f_enter(t_core s_in, mac_pkg::t_mode m, logic motion);
        t_core s;
        s = s_in;
        if (m != s_in.mode) begin
            s.mode = m;
            unique case (m)
                mac_pkg::MODE_DISARMED: begin
                    s.red   = 1'b0;
                    s.blink = '0;
                    s.beep  = '0;
                    s.phase = 1'b0;
                    s = f_emit(s, mac_pkg::EV_DISARMED, 16'd0);
                    if (s_in.mode == mac_pkg::MODE_ALARM) begin
                        s = f_emit(s, mac_pkg::EV_TOTAL, s_in.count);
                    end
                    s.count = '0;
                    s.prev  = motion;
                end
                mac_pkg::MODE_ARMED: begin
                    s.red   = 1'b1;
                    s.blink = '0;
                    s.beep  = '0;
                    s.phase = 1'b0;
                    s.count = '0;
                    s.prev  = motion;
                    s = f_emit(s, mac_pkg::EV_ARMED, 16'd0);
                end
                default: begin
                    s = f_emit(s, mac_pkg::EV_ALARM, 16'd0);
                end
            endcase
        end
        return s;
    endfunction

    // configuration registers
    logic [9:0] r_blink_ticks;
    logic [9:0] r_beep_ticks;
    logic [7:0] r_debounce_ticks;

    // alarm state
    mac_pkg::t_mode r_mode;
    logic [15:0]    r_trip_count;
    logic           r_prev_motion;
    logic           r_red;
    logic [9:0]     r_blink_count;
    logic [9:0]     r_beep_count;
    logic           r_beep_phase;
    logic           r_button_released;
    logic [7:0]     r_debounce_count;
    logic [LEN_W-1:0] r_line_len;
    logic [7:0]     r_line_chars [WORD_CHARS];

    // result queue
    mac_pkg::t_result r_fifo [FIFO_D];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    t_core            s;
    logic             n_button_released;
    logic [7:0]       n_debounce_count;
    logic [LEN_W-1:0] n_line_len;
    logic             char_wr;
    logic             pressed;
    logic             is_arm;
    logic             is_disarm;
    logic             is_status;
    logic             accept;
    logic             pop;
    logic [1:0]       push_n;
    mac_pkg::t_result res0;
    mac_pkg::t_result res1;

    assign accept = i_item.valid && i_item.ready;
    assign pop    = o_result.valid && o_result.ready;
    assign push_n = accept ? s.n : 2'd0;

    // command word match on the stored line
    assign is_arm = (r_line_len == LEN_W'(3)) &&
                    ({r_line_chars[0], r_line_chars[1], r_line_chars[2]} == mac_pkg::WORD_ARM);
    assign is_disarm = (r_line_len == LEN_W'(6)) &&
                       ({r_line_chars[0], r_line_chars[1], r_line_chars[2],
                         r_line_chars[3], r_line_chars[4], r_line_chars[5]}
                        == mac_pkg::WORD_DISARM);
    assign is_status = (r_line_len == LEN_W'(6)) &&
                       ({r_line_chars[0], r_line_chars[1], r_line_chars[2],
                         r_line_chars[3], r_line_chars[4], r_line_chars[5]}
                        == mac_pkg::WORD_STATUS);

    // next state and results of the item at the input
    always_comb begin
        s.mode  = r_mode;
        s.count = r_trip_count;
        s.prev  = r_prev_motion;
        s.red   = r_red;
        s.blink = r_blink_count;
        s.beep  = r_beep_count;
        s.phase = r_beep_phase;
        s.n     = 2'd0;
        s.code0 = mac_pkg::EV_NONE;
        s.tot0  = 16'd0;
        s.code1 = mac_pkg::EV_NONE;
        s.tot1  = 16'd0;
        n_button_released = r_button_released;
        n_debounce_count  = r_debounce_count;
        n_line_len        = r_line_len;
        char_wr           = 1'b0;
        pressed           = 1'b0;

        if (i_item.data.cmd) begin
            // command character
            if (i_item.data.rx_char == mac_pkg::CHAR_CR ||
                i_item.data.rx_char == mac_pkg::CHAR_LF) begin
                if (r_line_len != '0) begin
                    priority if (is_arm) begin
                        s = f_enter(s, mac_pkg::MODE_ARMED, i_item.data.motion_level);
                    end else if (is_disarm) begin
                        s = f_enter(s, mac_pkg::MODE_DISARMED, i_item.data.motion_level);
                    end else if (is_status) begin
                        s = f_emit(s, mac_pkg::EV_STATUS, s.count);
                    end else begin
                        s = f_emit(s, mac_pkg::EV_UNKNOWN, 16'd0);
                    end
                    n_line_len = '0;
                end
            end else if (int'(r_line_len) < LINE_MAX) begin
                char_wr    = (int'(r_line_len) < WORD_CHARS);
                n_line_len = r_line_len + 1'b1;
            end
        end else begin
            // button debounce
            if (i_item.data.button_level) begin
                n_button_released = 1'b1;
                n_debounce_count  = '0;
            end else if (r_button_released) begin
                if (r_debounce_count >= r_debounce_ticks) begin
                    pressed           = 1'b1;
                    n_button_released = 1'b0;
                    n_debounce_count  = '0;
                end else begin
                    n_debounce_count = r_debounce_count + 1'b1;
                end
            end
            if (pressed) begin
                s = f_enter(s, (s.mode == mac_pkg::MODE_DISARMED) ? mac_pkg::MODE_ARMED
                                                                   : mac_pkg::MODE_DISARMED,
                            i_item.data.motion_level);
            end

            // rising motion edge
            if (!s.prev && i_item.data.motion_level) begin
                if (s.mode == mac_pkg::MODE_ARMED) begin
                    s.count = 16'd1;
                    s = f_enter(s, mac_pkg::MODE_ALARM, i_item.data.motion_level);
                    s = f_emit(s, mac_pkg::EV_MOTION, s.count);
                end else if (s.mode == mac_pkg::MODE_ALARM) begin
                    s.count = s.count + 1'b1;
                    s = f_emit(s, mac_pkg::EV_MOTION, s.count);
                end
            end
            s.prev = i_item.data.motion_level;

            // led blink and buzzer beep
            if (s.mode != mac_pkg::MODE_ALARM) begin
                s.blink = '0;
                s.beep  = '0;
                s.phase = 1'b0;
            end else begin
                s.blink = s.blink + 1'b1;
                if (s.blink >= r_blink_ticks) begin
                    s.red   = ~s.red;
                    s.blink = '0;
                end
                s.beep = s.beep + 1'b1;
                if (s.beep >= r_beep_ticks) begin
                    s.beep  = '0;
                    s.phase = ~s.phase;
                end
            end
        end
    end

    // result items of this item
    always_comb begin
        res0.event_code   = s.code0;
        res0.motion_total = s.tot0;
        res0.mode_now     = s.mode;
        res0.red_led      = s.red;
        res0.green_led    = (s.mode == mac_pkg::MODE_DISARMED);
        res0.tone_on      = s.phase;
        res0.last_of_run  = (s.n == 2'd1);
        res1              = res0;
        res1.event_code   = s.code1;
        res1.motion_total = s.tot1;
        res1.last_of_run  = 1'b1;
    end

    // control state, configuration and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_ticks     <= mac_pkg::BLINK_TICKS_RST;
            r_beep_ticks      <= mac_pkg::BEEP_TICKS_RST;
            r_debounce_ticks  <= mac_pkg::DEBOUNCE_TICKS_RST;
            r_mode            <= mac_pkg::MODE_DISARMED;
            r_trip_count      <= '0;
            r_prev_motion     <= 1'b0;
            r_red             <= 1'b0;
            r_blink_count     <= '0;
            r_beep_count      <= '0;
            r_beep_phase      <= 1'b0;
            r_button_released <= 1'b1;
            r_debounce_count  <= '0;
            r_line_len        <= '0;
            r_wr_ptr          <= '0;
            r_rd_ptr          <= '0;
            r_count           <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mac_pkg::CFG_BLINK_TICKS:    r_blink_ticks    <= i_cfg_wdata;
                    mac_pkg::CFG_BEEP_TICKS:     r_beep_ticks     <= i_cfg_wdata;
                    mac_pkg::CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_mode            <= s.mode;
                r_trip_count      <= s.count;
                r_prev_motion     <= s.prev;
                r_red             <= s.red;
                r_blink_count     <= s.blink;
                r_beep_count      <= s.beep;
                r_beep_phase      <= s.phase;
                r_button_released <= n_button_released;
                r_debounce_count  <= n_debounce_count;
                r_line_len        <= n_line_len;
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    // queue entries and line characters
    always_ff @(posedge i_clk) begin
        if (accept && s.n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (accept && s.n == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= res1;
        end
        if (accept && char_wr) begin
            r_line_chars[IDX_W'(r_line_len)] <= i_item.data.rx_char;
        end
    end

    // channel handshakes
    assign i_item.ready   = (r_count <= CNT_W'(FIFO_D - 2));
    assign o_result.valid = (r_count != '0);
    assign o_result.data  = r_fifo[r_rd_ptr];

`ifndef SYNTH
    // queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_D))
        else $error("result queue overfilled");

    // green led follows the reported state
    a_green_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.data.green_led ==
                            (o_result.data.mode_now == mac_pkg::MODE_DISARMED)))
        else $error("green led disagrees with state");

    // motion count only runs while alarmed
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != mac_pkg::MODE_ALARM) |-> (r_trip_count == '0))
        else $error("motion count nonzero outside alarm");

    // buzzer and blink timers are quiet outside alarm
    a_effects_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != mac_pkg::MODE_ALARM) |->
            (r_beep_count == '0 && r_blink_count == '0 && !r_beep_phase))
        else $error("alarm effects running outside alarm");

    // a popped result that is not last is followed by another result
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !o_result.data.last_of_run) |=> o_result.valid)
        else $error("result run broken");
`endif

endmodule

[tb/sv/tb_motion_alarm_controller_unit.sv]
// self-checking testbench of the motion alarm controller unit
`timescale 1ns / 1ps

// predicts the result items of the alarm and checks them in order
class alarm_event_predictor;
    localparam int LINE_LIMIT = 19;
    localparam int WORD_LIMIT = 6;

    // configuration copy
    logic [9:0]             blink_ticks;
    logic [9:0]             beep_ticks;
    logic [7:0]             debounce_ticks;

    // alarm state copy
    mac_pkg::t_mode         mode;
    logic [15:0]            trip_count;
    logic                   prev_motion;
    logic                   button_released;
    logic [7:0]             debounce_count;
    logic [9:0]             blink_count;
    logic [9:0]             beep_count;
    logic                   red_on;
    logic                   beep_on;
    logic [7:0]             line_buf [WORD_LIMIT];
    int unsigned            line_len;

    // events raised by the item being worked on
    mac_pkg::t_event        item_codes [$];
    logic [15:0]            item_totals [$];

    mac_pkg::t_result       expected_events [$];
    int unsigned            errors;

    function new();
        blink_ticks     = mac_pkg::BLINK_TICKS_RST;
        beep_ticks      = mac_pkg::BEEP_TICKS_RST;
        debounce_ticks  = mac_pkg::DEBOUNCE_TICKS_RST;
        mode            = mac_pkg::MODE_DISARMED;
        trip_count      = '0;
        prev_motion     = 1'b0;
        button_released = 1'b1;
        debounce_count  = '0;
        blink_count     = '0;
        beep_count      = '0;
        red_on          = 1'b0;
        beep_on         = 1'b0;
        line_len        = 0;
        errors          = 0;
        foreach (line_buf[i]) line_buf[i] = '0;
    endfunction

    function void write_reg(logic [mac_pkg::CFG_IDX_W-1:0] idx,
                            logic [mac_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            mac_pkg::CFG_BLINK_TICKS:    blink_ticks = value;
            mac_pkg::CFG_BEEP_TICKS:     beep_ticks = value;
            mac_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks = value[7:0];
            default: ;
        endcase
    endfunction

    function void raise(mac_pkg::t_event code, logic [15:0] total);
        if (item_codes.size() < 2) begin
            item_codes.push_back(code);
            item_totals.push_back(total);
        end
    endfunction

    function void stop_effects();
        blink_count = '0;
        beep_count  = '0;
        beep_on     = 1'b0;
    endfunction

    // state change with its events; same state does nothing
    function void change_mode(mac_pkg::t_mode target, logic motion);
        mac_pkg::t_mode old;
        old = mode;
        if (target == old) return;
        mode = target;
        case (target)
            mac_pkg::MODE_DISARMED: begin
                red_on = 1'b0;
                stop_effects();
                raise(mac_pkg::EV_DISARMED, '0);
                if (old == mac_pkg::MODE_ALARM) raise(mac_pkg::EV_TOTAL, trip_count);
                trip_count  = '0;
                prev_motion = motion;
            end
            mac_pkg::MODE_ARMED: begin
                red_on = 1'b1;
                stop_effects();
                trip_count  = '0;
                prev_motion = motion;
                raise(mac_pkg::EV_ARMED, '0);
            end
            default: begin
                raise(mac_pkg::EV_ALARM, '0);
            end
        endcase
    endfunction

    // word is right-aligned, first character in the highest byte
    function bit line_matches(logic [47:0] word, int unsigned len);
        if (line_len != len) return 1'b0;
        for (int i = 0; i < len; i++)
            if (line_buf[i] != word[8*(len-1-i) +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function void take_char(logic [7:0] c, logic motion);
        if (c == mac_pkg::CHAR_CR || c == mac_pkg::CHAR_LF) begin
            if (line_len == 0) return;
            if (line_matches({24'd0, mac_pkg::WORD_ARM}, 3))
                change_mode(mac_pkg::MODE_ARMED, motion);
            else if (line_matches(mac_pkg::WORD_DISARM, 6))
                change_mode(mac_pkg::MODE_DISARMED, motion);
            else if (line_matches(mac_pkg::WORD_STATUS, 6))
                raise(mac_pkg::EV_STATUS, trip_count);
            else
                raise(mac_pkg::EV_UNKNOWN, '0);
            line_len = 0;
        end else if (line_len < LINE_LIMIT) begin
            if (line_len < WORD_LIMIT) line_buf[line_len] = c;
            line_len++;
        end
    endfunction

    function void take_tick(logic motion, logic button);
        bit pressed;
        pressed = 1'b0;
        // button debounce
        if (button) begin
            button_released = 1'b1;
            debounce_count  = '0;
        end else if (button_released) begin
            if (debounce_count >= debounce_ticks) begin
                pressed         = 1'b1;
                button_released = 1'b0;
                debounce_count  = '0;
            end else begin
                debounce_count = debounce_count + 8'd1;
            end
        end
        if (pressed) begin
            if (mode == mac_pkg::MODE_DISARMED) change_mode(mac_pkg::MODE_ARMED, motion);
            else change_mode(mac_pkg::MODE_DISARMED, motion);
        end
        // motion rising edge
        if (!prev_motion && motion) begin
            if (mode == mac_pkg::MODE_ARMED) begin
                trip_count = 16'd1;
                change_mode(mac_pkg::MODE_ALARM, motion);
                raise(mac_pkg::EV_MOTION, trip_count);
            end else if (mode == mac_pkg::MODE_ALARM) begin
                trip_count = trip_count + 16'd1;
                raise(mac_pkg::EV_MOTION, trip_count);
            end
        end
        prev_motion = motion;
        // blink and beep while alarmed
        if (mode != mac_pkg::MODE_ALARM) begin
            stop_effects();
            return;
        end
        blink_count = blink_count + 10'd1;
        if (blink_count >= blink_ticks) begin
            red_on      = ~red_on;
            blink_count = '0;
        end
        beep_count = beep_count + 10'd1;
        if (beep_count >= beep_ticks) begin
            beep_count = '0;
            beep_on    = ~beep_on;
        end
    endfunction

    // accepted input item: queue the result items it causes
    function void take_item(mac_pkg::t_item it);
        mac_pkg::t_result r;
        item_codes.delete();
        item_totals.delete();
        if (it.cmd) take_char(it.rx_char, it.motion_level);
        else take_tick(it.motion_level, it.button_level);
        foreach (item_codes[k]) begin
            r.event_code   = item_codes[k];
            r.motion_total = item_totals[k];
            r.mode_now     = mode;
            r.red_led      = red_on;
            r.green_led    = (mode == mac_pkg::MODE_DISARMED);
            r.tone_on      = beep_on;
            r.last_of_run  = (k == item_codes.size() - 1);
            expected_events.push_back(r);
        end
    endfunction

    function void report_field(string field, logic [15:0] want, logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_event(mac_pkg::t_result got);
        mac_pkg::t_result want;
        if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: result with no expected item: expected none, actual %h", $time, got);
            return;
        end
        want = expected_events.pop_front();
        if (got.event_code !== want.event_code)
            report_field("event_code", want.event_code, got.event_code);
        if (got.motion_total !== want.motion_total)
            report_field("motion_total", want.motion_total, got.motion_total);
        if (got.mode_now !== want.mode_now)
            report_field("mode_now", want.mode_now, got.mode_now);
        if (got.red_led !== want.red_led)
            report_field("red_led", want.red_led, got.red_led);
        if (got.green_led !== want.green_led)
            report_field("green_led", want.green_led, got.green_led);
        if (got.tone_on !== want.tone_on)
            report_field("tone_on", want.tone_on, got.tone_on);
        if (got.last_of_run !== want.last_of_run)
            report_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int unsigned pending();
        return expected_events.size();
    endfunction
endclass

module tb_motion_alarm_controller_unit;

    localparam int unsigned LIMIT_CYCLES  = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                cfg_we;
    logic [mac_pkg::CFG_IDX_W-1:0]       cfg_idx;
    logic [mac_pkg::CFG_DATA_W-1:0]      cfg_wdata;

    mac_item_if             item_bus ();
    mac_result_if           result_bus ();

    alarm_event_predictor   predictor;
    int unsigned            send_idle_pct;
    int unsigned            recv_stall_pct;
    int unsigned            items_sent;
    int unsigned            cycle_count;
    logic                   motion_lvl;

    motion_alarm_controller_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_bus),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // accepted input items feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && item_bus.valid && item_bus.ready) predictor.take_item(item_bus.data);
    end

    // result receiver with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) predictor.check_event(result_bus.data);
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one item after a random gap and hold it until taken
    task automatic offer_item(input logic cmd, input logic motion, input logic button,
                              input logic [7:0] ch);
        mac_pkg::t_item it;
        it.cmd          = cmd;
        it.motion_level = motion;
        it.button_level = button;
        it.rx_char      = ch;
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= it;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_tick(input logic button);
        offer_item(1'b0, motion_lvl, button, 8'($urandom_range(255)));
    endtask

    task automatic send_char(input logic [7:0] c);
        offer_item(1'b1, motion_lvl, 1'($urandom_range(1)), c);
    endtask

    // first count characters of a word, one optionally replaced, extra noise, then a terminator
    task automatic send_text(input logic [47:0] word, input int unsigned full_len,
                             input int unsigned count, input int bad_pos,
                             input int unsigned extra);
        logic [7:0] c;
        for (int i = 0; i < count; i++) begin
            c = word[8*(full_len-1-i) +: 8];
            if (i == bad_pos) c = 8'($urandom_range(255));
            send_char(c);
        end
        repeat (extra) send_char(8'($urandom_range(255)));
        send_char($urandom_range(1) ? mac_pkg::CHAR_LF : mac_pkg::CHAR_CR);
        // empty line now and then
        if ($urandom_range(9) == 0) send_char(mac_pkg::CHAR_CR);
    endtask

    // button low for some ticks then released
    task automatic press_button(input int unsigned low_ticks);
        repeat (low_ticks) begin
            if ($urandom_range(99) < 20) motion_lvl = ~motion_lvl;
            send_tick(1'b0);
        end
        send_tick(1'b1);
    endtask

    // stop sending and let every expected result come out
    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (predictor.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mac_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        predictor.write_reg(idx, value);
    endtask

    // random mix: mostly commands, motion runs and button presses
    task automatic run_random(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        int unsigned kind;
        int unsigned seq;
        int unsigned len;
        start = items_sent;
        seq   = 0;
        while (items_sent - start < budget) begin
            seq++;
            if (seq % 25 == 12) wait_idle();
            pick = $urandom_range(99);
            if (pick < 30) begin
                kind = $urandom_range(99);
                if (kind < 20)
                    send_text({24'd0, mac_pkg::WORD_ARM}, 3, 3, -1, 0);
                else if (kind < 35)
                    send_text(mac_pkg::WORD_DISARM, 6, 6, -1, 0);
                else if (kind < 50)
                    send_text(mac_pkg::WORD_STATUS, 6, 6, -1, 0);
                else if (kind < 65)
                    send_text(kind[0] ? mac_pkg::WORD_DISARM : mac_pkg::WORD_STATUS, 6,
                              $urandom_range(1, 6), $urandom_range(0, 7) - 1,
                              $urandom_range(0, 2));
                else
                    send_text(48'd0, 0, 0, -1, $urandom_range(0, 24));
            end else if (pick < 70) begin
                len = $urandom_range(1, 12);
                repeat (len) begin
                    if ($urandom_range(99) < 40) motion_lvl = ~motion_lvl;
                    send_tick(1'b1);
                end
            end else if (pick < 88) begin
                press_button(predictor.debounce_ticks + 1 + $urandom_range(2));
            end else begin
                // bounce shorter than the debounce time
                press_button($urandom_range(0, predictor.debounce_ticks));
            end
        end
    endtask

    // new register settings and idling pattern once the block is idle
    task automatic run_phase(input logic [9:0] blink, input logic [9:0] beep,
                             input logic [7:0] debounce, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned budget);
        wait_idle();
        write_reg(mac_pkg::CFG_BLINK_TICKS, blink);
        write_reg(mac_pkg::CFG_BEEP_TICKS, beep);
        write_reg(mac_pkg::CFG_DEBOUNCE_TICKS, {2'b00, debounce});
        cfg_we         <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        run_random(budget);
    endtask

    initial begin
        predictor        = new();
        i_rst_n          = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.data    = '0;
        result_bus.ready = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_wdata        = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        items_sent       = 0;
        cycle_count      = 0;
        motion_lvl       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at reset settings
        send_char(mac_pkg::CHAR_CR);
        send_text({24'd0, mac_pkg::WORD_ARM}, 3, 3, -1, 0);
        send_text({24'd0, mac_pkg::WORD_ARM}, 3, 3, -1, 0);
        motion_lvl = 1'b1;
        send_tick(1'b1);
        motion_lvl = 1'b0;
        send_tick(1'b1);
        motion_lvl = 1'b1;
        send_tick(1'b1);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(mac_pkg::CHAR_LF);
        send_text(mac_pkg::WORD_DISARM, 6, 6, -1, 0);
        wait_idle();

        // alarm count over a run of motion edges
        motion_lvl = 1'b0;
        send_text({24'd0, mac_pkg::WORD_ARM}, 3, 3, -1, 0);
        motion_lvl = 1'b1;
        send_tick(1'b1);
        repeat (20) begin
            motion_lvl = 1'b0;
            send_tick(1'b1);
            motion_lvl = 1'b1;
            send_tick(1'b1);
        end
        send_text(mac_pkg::WORD_STATUS, 6, 6, -1, 0);
        send_text(mac_pkg::WORD_DISARM, 6, 6, -1, 0);

        // random phases over settings and idling patterns
        run_phase(10'd2, 10'd3, 8'd1, 51, 0, 180);
        run_phase(10'd1, 10'd1, 8'd0, 0, 51, 180);
        run_phase(10'd1023, 10'd1023, 8'd255, 24, 24, 60);
        run_phase(10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                  8'($urandom_range(0, 10)), 0, 0, 180);
        run_phase(10'd7, 10'd5, 8'd3, 51, 51, 180);
        wait_idle();

        if (predictor.errors == 0 && predictor.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/mac_pkg.sv
rtl/mac_item_if.sv
rtl/mac_result_if.sv
rtl/motion_alarm_controller_unit.sv
tb/sv/tb_motion_alarm_controller_unit.sv
